FILE: hw/rtl/arpc_pkg.sv
// Shared types and codes for the ARP cache chain.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int ARPC_ENTRIES = 16;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;
  localparam int ACT_W = 2;
  localparam int ST_W  = 3;

  // action codes
  localparam logic [ACT_W-1:0] ACT_LEARN   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP  = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [ST_W-1:0] ST_DROPPED  = 3'd2;
  localparam logic [ST_W-1:0] ST_REPLY    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_US   = 3'd4;
  localparam logic [ST_W-1:0] ST_HIT      = 3'd5;
  localparam logic [ST_W-1:0] ST_MISS     = 3'd6;

  // Item walking down the cell chain.
  typedef struct packed {
    logic             vld;
    logic [ACT_W-1:0] act;
    logic [IP_W-1:0]  ip;        // peer_ip
    logic [MAC_W-1:0] mac;       // peer_mac, replaced by entry MAC on lookup hit
    logic [IP_W-1:0]  asked_ip;
    logic             done;      // a cell has consumed the item
    logic             ins;       // done by filling a free cell
  } arpc_tok_t;

endpackage

FILE: hw/rtl/arpc_cell.sv
// One cache entry of the chain: holds an IP/MAC pair and passes the item on.
// Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_cell
  import arpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  arpc_tok_t tok_in,
  output arpc_tok_t tok_out
);

  logic [IP_W-1:0]  ent_ip;
  logic [MAC_W-1:0] ent_mac;
  arpc_tok_t        tok;

  logic             live;
  logic             match;
  logic             is_free;
  logic             do_upd;
  logic             do_ins;
  logic             do_hit;
  arpc_tok_t        tok_next;

  always_comb begin
    live    = tok_in.vld && !tok_in.done && (tok_in.ip != '0);
    match   = live && (ent_ip == tok_in.ip);
    is_free = (ent_ip == '0);
    // free cells only form a tail, so every used cell was already checked
    do_upd  = match && (tok_in.act == ACT_LEARN);
    do_ins  = live && !match && is_free && (tok_in.act == ACT_LEARN);
    do_hit  = match && (tok_in.act == ACT_LOOKUP);

    tok_next = tok_in;
    if (do_upd || do_ins || do_hit) begin
      tok_next.done = 1'b1;
    end
    if (do_ins) begin
      tok_next.ins = 1'b1;
    end
    if (do_hit) begin
      tok_next.mac = ent_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_ip  <= '0;
      ent_mac <= '0;
      tok     <= '0;
    end else if (adv) begin
      tok <= tok_next;
      if (do_ins) begin
        ent_ip <= tok_in.ip;
      end
      if (do_upd || do_ins) begin
        ent_mac <= tok_in.mac;
      end
    end
  end

  assign tok_out = tok;

endmodule

FILE: hw/rtl/arpc_out.sv
// Result stage: turns the item leaving the chain into status/MAC and holds it.
// Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_out
  import arpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  arpc_tok_t        tok_in,
  input  logic [IP_W-1:0]  own_ip,
  output logic             out_valid,
  output logic [ST_W-1:0]  status,
  output logic [MAC_W-1:0] found_mac
);

  logic [ST_W-1:0]  status_next;
  logic [MAC_W-1:0] found_mac_next;

  always_comb begin
    status_next    = ST_MISS;
    found_mac_next = '0;
    case (tok_in.act)
      ACT_LEARN: begin
        if (tok_in.ip == '0) begin
          status_next = ST_DROPPED;
        end else if (tok_in.ins) begin
          status_next = ST_INSERTED;
        end else if (tok_in.done) begin
          status_next = ST_UPDATED;
        end else begin
          status_next = ST_DROPPED;
        end
      end
      ACT_REQUEST: begin
        if (tok_in.asked_ip == own_ip) begin
          status_next    = ST_REPLY;
          found_mac_next = tok_in.mac;
        end else begin
          status_next = ST_NOT_US;
        end
      end
      ACT_LOOKUP: begin
        if (tok_in.done) begin
          status_next    = ST_HIT;
          found_mac_next = tok_in.mac;
        end
      end
      default: begin
        status_next = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tok_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status    <= status_next;
      found_mac <= found_mac_next;
    end
  end

endmodule

FILE: hw/rtl/arp_cache_learn_lookup.sv
// ARP cache: ENTRIES cells in a chain, one item enters per cycle while the output is not stalled.
// Each input beat passes through every cell register in order, then the result register.
// Throughput one beat per cycle; the whole chain stalls while the output beat waits.
// Sync reset (rst high) frees every entry, clears own_ip and drops items in flight.
// No clearing pass: entry registers reset directly.
`timescale 1ns / 1ps

module arp_cache_learn_lookup
  import arpc_pkg::*;
#(
  parameter int ENTRIES = ARPC_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  // config write channel (own_ip)
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IP_W-1:0]  cfg_data,
  // input beats
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ACT_W-1:0] action,
  input  logic [IP_W-1:0]  peer_ip,
  input  logic [MAC_W-1:0] peer_mac,
  input  logic [IP_W-1:0]  asked_ip,
  // result beats
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ST_W-1:0]  status,
  output logic [MAC_W-1:0] found_mac
);

  // Items march down the chain in lockstep, so each cell sees the
  // effect of every earlier item before the next one arrives: order and
  // results match a one-at-a-time cache exactly.

  logic            adv;      // whole pipeline moves one step
  logic [IP_W-1:0] own_ip;
  arpc_tok_t       chain [ENTRIES+1];

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // the user must let own_ip change only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip <= '0;
    end else if (cfg_valid && cfg_ready) begin
      own_ip <= cfg_data;
    end
  end

  // item entering cell 0; a bubble when no beat is offered
  always_comb begin
    chain[0]          = '0;
    chain[0].vld      = in_valid;
    chain[0].act      = action;
    chain[0].ip       = peer_ip;
    chain[0].mac      = peer_mac;
    chain[0].asked_ip = asked_ip;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arpc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  // status/MAC decode and output register
  arpc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .tok_in    (chain[ENTRIES]),
    .own_ip    (own_ip),
    .out_valid (out_valid),
    .status    (status),
    .found_mac (found_mac)
  );

`ifndef SYNTHESIS
  // no new beat taken while a result is stalled
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while output stalled");

  // MAC only reported on hit or reply-due
  a_mac_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_HIT && status != ST_REPLY) |-> (found_mac == '0))
    else $error("found_mac nonzero for non-hit result");

  // status stays within the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_MISS))
    else $error("undefined status code");

  // an item leaving the chain shows up as a result beat next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (adv && chain[ENTRIES].vld) |=> out_valid)
    else $error("result beat lost at output stage");
`endif

endmodule
